// ===== hdl/mto_pkg.sv =====
// ----------------------------------------------------------------------------
// mto_pkg: shared definitions of the multichannel timed output
// Channel count, counter width, request codes and the per-channel entry
// and step records used by the sequencer and the channel step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mto_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int COUNT_WIDTH  = 16;
    localparam int MAX_RESULTS  = 8;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int N_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_STOP     = 2'd1;
    localparam logic [1:0] REQ_STOP_ALL = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic   active;
        logic   single;
        count_t on_len;
        count_t per_len;
        count_t cnt;
        logic   lvl;
    } entry_t;

    typedef struct packed {
        logic [1:0] req_type;
        count_t     on_ticks;
        count_t     period_ticks;
        logic       one_shot;
        logic       room;
    } step_req_t;

    typedef struct packed {
        logic emit;
        logic level;
        logic done;
    } step_res_t;

endpackage

`default_nettype wire

// ===== hdl/multichannel_timed_output.sv =====
// ----------------------------------------------------------------------------
// multichannel_timed_output: per-channel PWM and one-shot pulse timer
// Sequencer, channel state and output staging around a shared step unit.
// ----------------------------------------------------------------------------
// A start or stop beat steps its one channel and then flushes, or flushes at
// once when its channel is out of range; a tick or stop-all beat walks the
// channels through the one step unit, one channel per cycle while the result
// side does not stall. Either kind is held while the result side stalls. The
// input is not ready while a beat is being worked. Results carry the channel,
// the commanded level and a pulse-done flag; tlast marks the final result of
// a beat, and a beat that changes nothing gives no result.
`default_nettype none

module multichannel_timed_output (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] channel, [21:6] on_ticks, [37:22] period_ticks, [38] one_shot, [39] zero
    input  wire logic [39:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] out_channel, [6] level, [7] pulse_done
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import mto_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CH_W-1:0] idx_reg, idx_next;
    logic            one_reg, one_next;
    logic [N_W-1:0]  n_reg, n_next;
    step_req_t       req_reg;
    entry_t          ent_reg [NUM_CHANNELS];

    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_reg, pend_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      m_tdata_reg, m_tdata_next;
    logic            m_tlast_reg, m_tlast_next;

    step_req_t step_req;
    entry_t    cur_entry, new_entry;
    step_res_t step_res;
    logic      out_free, can_go, commit, last_step, accept, ch_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ch_ok    = {1'b0, s_tdata[5:0]} < 7'(NUM_CHANNELS);

    always_comb begin
        step_req      = req_reg;
        step_req.room = n_reg < N_W'(MAX_RESULTS);
    end

    assign cur_entry = ent_reg[idx_reg];

    mto_step_unit u_step (
        .req        (step_req),
        .entry      (cur_entry),
        .entry_next (new_entry),
        .res        (step_res)
    );

    // A new result may displace the pending one only if the output slot is free.
    assign can_go    = !step_res.emit || !pend_valid_reg || out_free;
    assign commit    = (state_reg == ST_WALK) && can_go;
    assign last_step = one_reg || (idx_reg == CH_W'(NUM_CHANNELS - 1));

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        one_next        = one_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next = '0;
                    if (s_tuser == REQ_START || s_tuser == REQ_STOP) begin
                        idx_next   = s_tdata[CH_W-1:0];
                        one_next   = 1'b1;
                        state_next = ch_ok ? ST_WALK : ST_FLUSH;
                    end else begin
                        idx_next   = '0;
                        one_next   = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (can_go) begin
                    if (step_res.emit) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = pend_reg;
                            m_tlast_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = {step_res.done, step_res.level, 6'(idx_reg)};
                        n_next          = n_reg + N_W'(1);
                    end
                    if (last_step) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + CH_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = pend_reg;
                    m_tlast_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            one_reg        <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                ent_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            one_reg        <= one_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (commit) begin
                ent_reg[idx_reg] <= new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (accept) begin
            req_reg.req_type     <= s_tuser;
            req_reg.on_ticks     <= COUNT_WIDTH'(s_tdata[21:6]);
            req_reg.period_ticks <= COUNT_WIDTH'(s_tdata[37:22]);
            req_reg.one_shot     <= s_tdata[38];
            req_reg.room         <= 1'b1;
        end
    end

    // A new beat is only taken once the previous beat's results are all staged.
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("input ready while a result is still pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= N_W'(MAX_RESULTS))
        else $error("result count above the per-beat limit");

    // A result sent without tlast must leave a later result still pending.
    a_not_last_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && step_res.emit && pend_valid_reg) |=> (pend_valid_reg && !m_tlast_reg))
        else $error("non-final result sent with nothing pending behind it");

endmodule

`default_nettype wire

// ===== hdl/mto_step_unit.sv =====
// ----------------------------------------------------------------------------
// mto_step_unit: one channel step
// Applies one request to one channel entry: arming, stopping, or advancing
// the tick counter with its compares. The sequencer reuses it per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mto_step_unit (
    input  mto_pkg::step_req_t req,
    input  mto_pkg::entry_t    entry,
    output mto_pkg::entry_t    entry_next,
    output mto_pkg::step_res_t res
);
    import mto_pkg::*;

    logic [COUNT_WIDTH:0] inc;
    logic                 start_ok;
    logic                 want;

    assign inc = {1'b0, entry.cnt} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign start_ok = (req.on_ticks != '0) &&
                      (req.one_shot || (req.period_ticks >= req.on_ticks));

    always_comb begin
        entry_next = entry;
        res        = '0;
        want       = 1'b0;
        unique case (req.req_type)
            REQ_START: begin
                if (start_ok) begin
                    entry_next.active  = 1'b1;
                    entry_next.single  = req.one_shot;
                    entry_next.on_len  = req.on_ticks;
                    entry_next.per_len = req.period_ticks;
                    entry_next.cnt     = '0;
                    entry_next.lvl     = 1'b1;
                    res.emit           = 1'b1;
                    res.level          = 1'b1;
                end
            end
            REQ_STOP, REQ_STOP_ALL: begin
                if (entry.active && req.room) begin
                    entry_next.active = 1'b0;
                    entry_next.lvl    = 1'b0;
                    res.emit          = 1'b1;
                end
            end
            REQ_TICK: begin
                if (entry.active) begin
                    if (entry.single) begin
                        // The counter saturates so a held-off end is seen again.
                        entry_next.cnt = inc[COUNT_WIDTH] ? entry.cnt : inc[COUNT_WIDTH-1:0];
                        if (entry_next.cnt < entry.on_len) begin
                            want = 1'b1;
                            if (want != entry.lvl && req.room) begin
                                entry_next.lvl = want;
                                res.emit       = 1'b1;
                                res.level      = want;
                            end
                        end else if (req.room) begin
                            entry_next.active = 1'b0;
                            entry_next.lvl    = 1'b0;
                            res.emit          = 1'b1;
                            res.done          = 1'b1;
                        end
                    end else begin
                        entry_next.cnt = (inc >= {1'b0, entry.per_len}) ? '0
                                                                         : inc[COUNT_WIDTH-1:0];
                        want = entry_next.cnt < entry.on_len;
                        if (want != entry.lvl && req.room) begin
                            entry_next.lvl = want;
                            res.emit       = 1'b1;
                            res.level      = want;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
